FILE: design/mssc_pkg.sv
`timescale 1ns / 1ps

package mssc_pkg;

    localparam int QUERY_W  = 10;
    localparam int RESULT_W = 3;
    localparam int BEST_W   = 4;

    localparam logic [BEST_W-1:0] BEST_INIT = 4'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EXT_INIT,
        ST_EXT_READ,
        ST_EXT_DRAIN,
        ST_EXT_WRITE,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture_query;
        logic ext_begin;
        logic ext_init;
        logic ext_read;
        logic ext_write;
        logic res_zero;
        logic res_from_rd;
        logic res_from_best;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic query_over;
        logic query_hit;
        logic sq_next_over;
        logic ext_last;
        logic out_busy;
    } status_t;

endpackage

FILE: design/mssc_ifs.sv
`timescale 1ns / 1ps

interface mssc_query_if
    import mssc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [QUERY_W-1:0] query_value;

    modport source (output valid, output query_value, input ready);
    modport sink (input valid, input query_value, output ready);
endinterface

interface mssc_result_if
    import mssc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [RESULT_W-1:0] min_squares;

    modport source (output valid, output min_squares, input ready);
    modport sink (input valid, input min_squares, output ready);
endinterface

FILE: design/min_square_sum_count_unit.sv
`timescale 1ns / 1ps

// Answers, for each query beat, the least number of perfect squares that sum to the
// query (0 to 4; a query above MAX_N answers 0 and changes nothing). Answers are
// memoized in a MAX_N+1 entry table that needs no clearing pass after reset. A query
// that falls inside the filled part of the table is read from it, and its result is
// loaded once the output is free. A query beyond it first extends the table one
// entry at a time; each entry i is built through the single read port of the table,
// which fetches one earlier entry per cycle for each square not above i. The block
// handles one query at a time and takes the next one while its last result waits.
module min_square_sum_count_unit
    import mssc_pkg::*;
#(
    parameter int MAX_N = 1023
)
(
    input  logic          clk,
    input  logic          rst_n,
    mssc_query_if.sink    query,
    mssc_result_if.source result
);

    cmd_t    cmd;
    status_t status;

    mssc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (query.valid),
        .in_ready (query.ready),
        .status   (status),
        .cmd      (cmd)
    );

    mssc_dp #(
        .MAX_N (MAX_N)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .query_value (query.query_value),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .min_squares (result.min_squares)
    );

endmodule

FILE: design/mssc_ctrl.sv
`timescale 1ns / 1ps

module mssc_ctrl
    import mssc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready          = 1'b1;
                cmd.capture_query = in_valid;
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.query_over)
                begin
                    cmd.res_zero = 1'b1;
                    state_next   = ST_FINISH;
                end
                else if (status.query_hit)
                begin
                    state_next = ST_RD_ISSUE;
                end
                else
                begin
                    cmd.ext_begin = 1'b1;
                    state_next    = ST_EXT_INIT;
                end
            end
            ST_EXT_INIT:
            begin
                cmd.ext_init = 1'b1;
                state_next   = ST_EXT_READ;
            end
            ST_EXT_READ:
            begin
                cmd.ext_read = 1'b1;
                if (status.sq_next_over)
                begin
                    state_next = ST_EXT_DRAIN;
                end
            end
            ST_EXT_DRAIN:
            begin
                state_next = ST_EXT_WRITE;
            end
            ST_EXT_WRITE:
            begin
                cmd.ext_write = 1'b1;
                if (status.ext_last)
                begin
                    cmd.res_from_best = 1'b1;
                    state_next        = ST_FINISH;
                end
                else
                begin
                    state_next = ST_EXT_INIT;
                end
            end
            ST_RD_ISSUE:
            begin
                state_next = ST_RD_WAIT;
            end
            ST_RD_WAIT:
            begin
                cmd.res_from_rd = 1'b1;
                state_next      = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/mssc_dp.sv
`timescale 1ns / 1ps

module mssc_dp
    import mssc_pkg::*;
#(
    parameter int MAX_N = 1023
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output status_t             status,
    input  logic [QUERY_W-1:0]  query_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [RESULT_W-1:0] min_squares
);

    localparam int AW = (MAX_N < 1) ? 1 : $clog2(MAX_N + 1);
    localparam int FW = $clog2(MAX_N + 2);
    localparam int SW = AW + 2;
    localparam int CW = (QUERY_W > FW) ? QUERY_W : FW;

    logic [RESULT_W-1:0] mem [0:MAX_N];

    logic [QUERY_W-1:0]  query_reg;
    logic [FW-1:0]       filled_reg;
    logic [AW-1:0]       cur_i_reg;
    logic [AW-1:0]       j_reg;
    logic [SW-1:0]       sq_reg;
    logic [BEST_W-1:0]   best_reg;
    logic                acc_pend_reg;
    logic [RESULT_W-1:0] rd_raw_reg;
    logic                rd_zero_reg;
    logic [RESULT_W-1:0] result_reg;
    logic                out_valid_reg;
    logic [RESULT_W-1:0] out_data_reg;

    logic [CW-1:0]       q_ext;
    logic [AW-1:0]       q_addr;
    logic [SW-1:0]       sq_next;
    logic [AW-1:0]       ext_addr;
    logic [AW-1:0]       rd_addr;
    logic [RESULT_W-1:0] rd_data;
    logic [BEST_W-1:0]   cand;

    assign q_ext    = CW'(query_reg);
    assign q_addr   = q_ext[AW-1:0];
    assign sq_next  = sq_reg + SW'({j_reg, 1'b1});
    assign ext_addr = cur_i_reg - sq_reg[AW-1:0];
    assign rd_addr  = cmd.ext_read ? ext_addr : q_addr;
    assign rd_data  = rd_zero_reg ? '0 : rd_raw_reg;
    assign cand     = BEST_W'(rd_data) + BEST_W'(1);

    assign status.query_over   = q_ext > CW'(MAX_N);
    assign status.query_hit    = q_ext < CW'(filled_reg);
    assign status.sq_next_over = sq_next > SW'(cur_i_reg);
    assign status.ext_last     = cur_i_reg == q_addr;
    assign status.out_busy     = out_valid_reg && !out_ready;

    // Entry zero is never written; reads of it are forced to zero instead.
    always_ff @(posedge clk)
    begin
        if (cmd.ext_write)
        begin
            mem[cur_i_reg] <= best_reg[RESULT_W-1:0];
        end
        rd_raw_reg  <= mem[rd_addr];
        rd_zero_reg <= rd_addr == '0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture_query)
        begin
            query_reg <= query_value;
        end
        if (cmd.ext_begin)
        begin
            cur_i_reg <= filled_reg[AW-1:0];
        end
        else if (cmd.ext_write)
        begin
            cur_i_reg <= cur_i_reg + AW'(1);
        end
        if (cmd.ext_init)
        begin
            j_reg  <= AW'(1);
            sq_reg <= SW'(1);
        end
        else if (cmd.ext_read)
        begin
            j_reg  <= j_reg + AW'(1);
            sq_reg <= sq_next;
        end
        if (cmd.ext_init)
        begin
            best_reg <= BEST_INIT;
        end
        else if (acc_pend_reg && (cand < best_reg))
        begin
            best_reg <= cand;
        end
        if (cmd.res_zero)
        begin
            result_reg <= '0;
        end
        else if (cmd.res_from_rd)
        begin
            result_reg <= rd_data;
        end
        else if (cmd.res_from_best)
        begin
            result_reg <= best_reg[RESULT_W-1:0];
        end
        if (cmd.out_load)
        begin
            out_data_reg <= result_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg    <= FW'(1);
            acc_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_pend_reg <= cmd.ext_read;
            if (cmd.ext_write)
            begin
                filled_reg <= FW'(cur_i_reg) + FW'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign min_squares = out_data_reg;

endmodule

FILE: design/mssc_checker.sv
`timescale 1ns / 1ps

module mssc_checker
    import mssc_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [RESULT_W-1:0] min_squares
);

    // Every count lies between zero and four.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (min_squares <= RESULT_W'(4)))
        else $error("min_squares above four");

    // After a query beat the block is busy with it and takes no query in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("query accepted back to back");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(min_squares))
        else $error("result beat changed while stalled");

endmodule

bind min_square_sum_count_unit mssc_checker u_mssc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (query.valid),
    .in_ready    (query.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .min_squares (result.min_squares)
);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mssc_pkg::*;

    localparam int MAX_N      = 1023;
    localparam int IDLE_LIMIT = 150000;
    localparam int DRAIN_WAIT = 40;
    localparam int RANDOM_ITEMS = 1200;

    typedef struct {
        logic [QUERY_W-1:0]  query;
        bit                  fixed;
        logic [RESULT_W-1:0] count;
    } query_row_t;

    typedef struct {
        bit                  fixed;
        logic [RESULT_W-1:0] count;
    } known_count_t;

    logic clk;
    logic rst_n;

    mssc_query_if  query_bus ();
    mssc_result_if result_bus ();

    min_square_sum_count_unit #(
        .MAX_N (MAX_N)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query_bus),
        .result (result_bus)
    );

    logic [RESULT_W-1:0] square_count_memo [0:MAX_N];
    int unsigned         memo_fill;

    logic [RESULT_W-1:0] pending_counts [$];
    known_count_t        known_counts [$];

    int mismatches;
    int queries_sent;
    int extending_queries;
    int answers_seen;
    int idle_cycles;
    int sent_limit;

    query_row_t directed_rows [] = '{
        '{10'd0,  1'b1, 3'd0}, '{10'd1,  1'b1, 3'd1}, '{10'd2,  1'b1, 3'd2},
        '{10'd3,  1'b1, 3'd3}, '{10'd4,  1'b1, 3'd1}, '{10'd5,  1'b0, 3'd0},
        '{10'd6,  1'b0, 3'd0}, '{10'd7,  1'b1, 3'd4}, '{10'd8,  1'b0, 3'd0},
        '{10'd9,  1'b1, 3'd1}, '{10'd10, 1'b0, 3'd0}, '{10'd0,  1'b1, 3'd0},
        '{10'd12, 1'b0, 3'd0}, '{10'd15, 1'b1, 3'd4}, '{10'd16, 1'b1, 3'd1},
        '{10'd17, 1'b0, 3'd0}, '{10'd23, 1'b1, 3'd4}, '{10'd25, 1'b1, 3'd1},
        '{10'd28, 1'b1, 3'd4}, '{10'd31, 1'b1, 3'd4}, '{10'd30, 1'b0, 3'd0},
        '{10'd3,  1'b1, 3'd3}, '{10'd64, 1'b1, 3'd1}, '{10'd63, 1'b1, 3'd4},
        '{10'd100, 1'b1, 3'd1}
    };

    function automatic logic [RESULT_W-1:0] min_squares_of(input int unsigned n);
        logic [BEST_W-1:0] best;
        int unsigned       i;
        int unsigned       j;
        if (n > MAX_N)
        begin
            return '0;
        end
        if (n >= memo_fill)
        begin
            for (i = memo_fill; i <= n; i++)
            begin
                best = 4'd7;
                for (j = 1; j * j <= i; j++)
                begin
                    if ({1'b0, square_count_memo[i - j * j]} + 4'd1 < best)
                    begin
                        best = {1'b0, square_count_memo[i - j * j]} + 4'd1;
                    end
                end
                square_count_memo[i] = best[RESULT_W-1:0];
            end
            memo_fill = n + 1;
        end
        return square_count_memo[n];
    endfunction

    task automatic send_query(input logic [QUERY_W-1:0] q, input bit fixed,
                              input logic [RESULT_W-1:0] count);
        int           gap;
        int           pick;
        known_count_t entry;
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            gap = 0;
        end
        else if (pick < 95)
        begin
            gap = $urandom_range(1, 3);
        end
        else
        begin
            gap = $urandom_range(8, 40);
        end
        if (gap > 0)
        begin
            query_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        entry.fixed  = fixed;
        entry.count  = count;
        known_counts = {known_counts, entry};
        if (int'(q) >= sent_limit)
        begin
            extending_queries++;
            sent_limit = int'(q) + 1;
        end
        query_bus.valid       <= 1'b1;
        query_bus.query_value <= q;
        do
        begin
            @(posedge clk);
        end
        while (!query_bus.ready);
        queries_sent++;
    endtask

    task automatic wait_for_answers();
        query_bus.valid <= 1'b0;
        while (pending_counts.size() != 0 || known_counts.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        known_count_t   known;
        logic [RESULT_W-1:0] predicted;
        if (rst_n && query_bus.valid && query_bus.ready)
        begin
            predicted = min_squares_of(query_bus.query_value);
            if (known_counts.size() != 0)
            begin
                known = known_counts.pop_front();
                if (known.fixed)
                begin
                    predicted = known.count;
                end
            end
            pending_counts = {pending_counts, predicted};
        end
    end

    always @(posedge clk)
    begin
        logic [RESULT_W-1:0] wanted;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            answers_seen++;
            if (pending_counts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: unexpected result beat, min_squares=%0d",
                             $realtime, result_bus.min_squares);
                end
            end
            else
            begin
                wanted = pending_counts.pop_front();
                if (result_bus.min_squares !== wanted)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: min_squares mismatch, expected %0d, got %0d",
                                 $realtime, wanted, result_bus.min_squares);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        int hold;
        int pick;
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
        end
        else if (hold > 0)
        begin
            hold--;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                result_bus.ready <= 1'b1;
                hold = $urandom_range(1, 40);
            end
            else if (pick < 96)
            begin
                result_bus.ready <= 1'b0;
                hold = $urandom_range(1, 3);
            end
            else
            begin
                result_bus.ready <= 1'b0;
                hold = $urandom_range(10, 60);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((query_bus.valid && query_bus.ready) ||
                (result_bus.valid && result_bus.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timed out after %0d cycles with no beat", idle_cycles);
                $display("min_square_sum_count_unit regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int k;
        int pick;
        int q;
        rst_n                 = 1'b0;
        query_bus.valid       = 1'b0;
        query_bus.query_value = '0;
        memo_fill             = 1;
        square_count_memo[0]  = '0;
        mismatches            = 0;
        queries_sent          = 0;
        extending_queries     = 0;
        answers_seen          = 0;
        idle_cycles           = 0;
        sent_limit            = 1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            send_query(directed_rows[r].query, directed_rows[r].fixed,
                       directed_rows[r].count);
        end
        wait_for_answers();

        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == RANDOM_ITEMS / 2)
            begin
                wait_for_answers();
            end
            pick = $urandom_range(0, 99);
            if (sent_limit <= MAX_N && pick < 3)
            begin
                q = $urandom_range(sent_limit, MAX_N);
            end
            else if (sent_limit <= MAX_N && pick < 55)
            begin
                q = sent_limit + $urandom_range(0, 10);
                if (q > MAX_N)
                begin
                    q = MAX_N;
                end
            end
            else
            begin
                q = $urandom_range(0, sent_limit - 1);
            end
            send_query(q[QUERY_W-1:0], 1'b0, '0);
        end
        send_query(10'd1023, 1'b1, 3'd4);
        wait_for_answers();
        repeat (DRAIN_WAIT) @(posedge clk);

        if (pending_counts.size() != 0)
        begin
            mismatches++;
        end
        $display("Sent %0d queries, %0d of them growing the table, and checked %0d answers.",
                 queries_sent, extending_queries, answers_seen);
        $display("The table was filled up to %0d with random gaps and stalls on both sides.",
                 memo_fill - 1);
        if (mismatches == 0)
        begin
            $display("min_square_sum_count_unit regression: pass");
        end
        else
        begin
            $display("%0d mismatches in total", mismatches);
            $display("min_square_sum_count_unit regression: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/mssc_pkg.sv
design/mssc_ifs.sv
design/mssc_ctrl.sv
design/mssc_dp.sv
design/min_square_sum_count_unit.sv
design/mssc_checker.sv
bench/tb_top.sv
